// ===== hw/rtl/cstq_pkg.sv =====
// Shared types and constants for the class-selective ticket queue.
// Used by cstq_cell and class_selective_ticket_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cstq_pkg;

    // Field widths
    localparam int NUM_W  = 16;
    localparam int CLS_W  = 2;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 6;
    localparam int MAP_W  = 8;

    // Operation codes
    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    // Class codes
    localparam logic [CLS_W-1:0] CLS_COMMON   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_PRIORITY = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FAST     = 2'd2;
    localparam logic [CLS_W-1:0] CLS_INVALID  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_ISSUED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_SERVED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADCLASS = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOMATCH  = 3'd5;

    // Window map reset: window 0 priority, 1 and 2 common, 3 fast
    localparam logic [MAP_W-1:0] MAP_RESET = 8'd129;

    localparam logic [NUM_W-1:0] NUM_RESET = 16'd1;

    // Search token travelling down the chain of cells
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [NUM_W-1:0] num;
        logic [CLS_W-1:0] cls;
    } pkt_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic             append;
        logic [CLS_W-1:0] want;
        logic [NUM_W-1:0] num;
        logic [CLS_W-1:0] cls;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cstq_cell.sv =====
// One queue slot: holds a ticket and forwards the search token to the next slot.
// Depends on cstq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cstq_cell #(
    parameter int IDX   = 0,
    parameter int OCC_W = 6
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  cstq_pkg::cell_ctl_t       ctl,
    input  wire  [OCC_W-1:0]          occ,
    input  cstq_pkg::pkt_t            pkt_in,
    input  wire  [cstq_pkg::NUM_W-1:0] nb_num,
    input  wire  [cstq_pkg::CLS_W-1:0] nb_cls,
    output cstq_pkg::pkt_t            pkt_out,
    output logic [cstq_pkg::NUM_W-1:0] num_out,
    output logic [cstq_pkg::CLS_W-1:0] cls_out
);

    cstq_pkg::pkt_t             pkt_reg;
    cstq_pkg::pkt_t             pkt_next;
    logic [cstq_pkg::NUM_W-1:0] num_reg;
    logic [cstq_pkg::NUM_W-1:0] num_next;
    logic [cstq_pkg::CLS_W-1:0] cls_reg;
    logic [cstq_pkg::CLS_W-1:0] cls_next;
    logic                       in_range;
    logic                       is_tail;
    logic                       match;
    logic                       shift;

    // Decide whether this slot is occupied, the append target, or hit
    always_comb
    begin
        in_range = (occ > OCC_W'(IDX));
        is_tail  = (occ == OCC_W'(IDX));
        match    = pkt_in.valid && !pkt_in.hit && in_range && (cls_reg == ctl.want);
        shift    = pkt_in.valid && (pkt_in.hit || match);
    end

    // Capture the ticket into the token on a hit, else pass the token on
    always_comb
    begin
        pkt_next = pkt_in;
        if (match)
        begin
            pkt_next.hit = 1'b1;
            pkt_next.num = num_reg;
            pkt_next.cls = cls_reg;
        end
    end

    // Append at the tail, or close the gap by taking the neighbour's ticket
    always_comb
    begin
        num_next = num_reg;
        cls_next = cls_reg;
        if (ctl.append && is_tail)
        begin
            num_next = ctl.num;
            cls_next = ctl.cls;
        end
        else if (shift)
        begin
            num_next = nb_num;
            cls_next = nb_cls;
        end
    end

    // Token register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

    // Ticket storage
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        cls_reg <= cls_next;
    end

    assign pkt_out = pkt_reg;
    assign num_out = num_reg;
    assign cls_out = cls_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/class_selective_ticket_queue.sv =====
// Class-selective ticket queue: controller, window map and the chain of slots.
// Depends on cstq_pkg and cstq_cell.
// Issue, a full or bad-class refusal and a serve on an empty queue: result
// strobed on done in the cycle after start is taken; the next item is taken then.
// Serve: result set by the token walking the slot chain; busy holds new items off till done.
// Reset clears the occupancy, sets the next number to 1 and the map to 129.
// The receiver cannot stall: each result is shown for one cycle on done.
`timescale 1ns / 1ps
`default_nettype none

module class_selective_ticket_queue #(
    parameter int DEPTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          op,
    input  wire  [cstq_pkg::CLS_W-1:0]   ticket_class,
    input  wire  [1:0]                   window,
    input  wire                          cfg_we,
    input  wire  [cstq_pkg::MAP_W-1:0]   cfg_wdata,
    output logic                         done,
    output logic [cstq_pkg::STAT_W-1:0]  status,
    output logic [cstq_pkg::NUM_W-1:0]   served_number,
    output logic [cstq_pkg::CLS_W-1:0]   served_class,
    output logic [cstq_pkg::CNT_W-1:0]   queue_count
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                         state_reg, state_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic [OCC_W-1:0]             occ_inc, occ_dec;
    logic [cstq_pkg::NUM_W-1:0]   next_num_reg, next_num_next;
    logic [cstq_pkg::MAP_W-1:0]   map_reg;
    logic [cstq_pkg::CLS_W-1:0]   want_reg, want_next;
    logic [cstq_pkg::CLS_W-1:0]   want_comb;
    logic                         inject_reg, inject_next;
    logic                         done_reg, done_next;
    logic [cstq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [cstq_pkg::NUM_W-1:0]   number_reg, number_next;
    logic [cstq_pkg::CLS_W-1:0]   class_reg, class_next;
    logic [cstq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         accept;
    cstq_pkg::cell_ctl_t          ctl;
    cstq_pkg::pkt_t               chain [DEPTH+1];
    cstq_pkg::pkt_t               last_pkt;
    logic [cstq_pkg::NUM_W-1:0]   num_arr [DEPTH];
    logic [cstq_pkg::CLS_W-1:0]   cls_arr [DEPTH];
    logic [DEPTH-1:0]             tok_vec;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign occ_inc  = occ_reg + 1'b1;
    assign occ_dec  = occ_reg - 1'b1;
    assign want_comb = map_reg[{window, 1'b0} +: 2];
    assign last_pkt = chain[DEPTH];

    // Inject the search token into the head slot
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = inject_reg;
    end

    // Build the chain of slots
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [cstq_pkg::NUM_W-1:0] nb_num;
            logic [cstq_pkg::CLS_W-1:0] nb_cls;

            if (gi == DEPTH - 1)
            begin : g_last
                assign nb_num = '0;
                assign nb_cls = '0;
            end
            else
            begin : g_mid
                assign nb_num = num_arr[gi+1];
                assign nb_cls = cls_arr[gi+1];
            end

            cstq_cell #(
                .IDX   (gi),
                .OCC_W (OCC_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .occ     (occ_reg),
                .pkt_in  (chain[gi]),
                .nb_num  (nb_num),
                .nb_cls  (nb_cls),
                .pkt_out (chain[gi+1]),
                .num_out (num_arr[gi]),
                .cls_out (cls_arr[gi])
            );

            assign tok_vec[gi] = chain[gi+1].valid;
        end
    endgenerate

    // Control: take items, start the scan, finish on the token leaving the chain
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        next_num_next = next_num_reg;
        want_next     = want_reg;
        inject_next   = 1'b0;
        done_next     = 1'b0;
        status_next   = status_reg;
        number_next   = number_reg;
        class_next    = class_reg;
        count_next    = count_reg;
        ctl.append    = 1'b0;
        ctl.want      = want_reg;
        ctl.num       = next_num_reg;
        ctl.cls       = ticket_class;

        if (accept)
        begin
            unique case (op)
                cstq_pkg::OP_ISSUE:
                begin
                    done_next   = 1'b1;
                    number_next = '0;
                    class_next  = '0;
                    count_next  = cstq_pkg::CNT_W'(occ_reg);
                    priority if (occ_reg == OCC_W'(DEPTH))
                    begin
                        status_next = cstq_pkg::ST_FULL;
                    end
                    else if (ticket_class == cstq_pkg::CLS_INVALID)
                    begin
                        status_next = cstq_pkg::ST_BADCLASS;
                    end
                    else
                    begin
                        ctl.append    = 1'b1;
                        status_next   = cstq_pkg::ST_ISSUED;
                        number_next   = next_num_reg;
                        class_next    = ticket_class;
                        count_next    = cstq_pkg::CNT_W'(occ_inc);
                        occ_next      = occ_inc;
                        next_num_next = next_num_reg + 1'b1;
                    end
                end
                cstq_pkg::OP_SERVE:
                begin
                    if (occ_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = cstq_pkg::ST_EMPTY;
                        number_next = '0;
                        class_next  = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        want_next   = want_comb;
                        inject_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else if (state_reg == ST_SCAN && last_pkt.valid)
        begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
            if (last_pkt.hit)
            begin
                status_next = cstq_pkg::ST_SERVED;
                number_next = last_pkt.num;
                class_next  = last_pkt.cls;
                count_next  = cstq_pkg::CNT_W'(occ_dec);
                occ_next    = occ_dec;
            end
            else
            begin
                status_next = cstq_pkg::ST_NOMATCH;
                number_next = '0;
                class_next  = '0;
                count_next  = cstq_pkg::CNT_W'(occ_reg);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            next_num_reg <= cstq_pkg::NUM_RESET;
            map_reg      <= cstq_pkg::MAP_RESET;
            inject_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            next_num_reg <= next_num_next;
            inject_reg   <= inject_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                map_reg <= cfg_wdata;
            end
        end
    end

    // Result and scan payload registers
    always_ff @(posedge clk)
    begin
        want_reg   <= want_next;
        status_reg <= status_next;
        number_reg <= number_next;
        class_reg  <= class_next;
        count_reg  <= count_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign served_number = number_reg;
    assign served_class  = class_reg;
    assign queue_count   = count_reg;

    // Only one token may be in the chain at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the slot chain");

    // A token is only injected or delivered while scanning
    a_inject_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (inject_reg || last_pkt.valid) |-> (state_reg == ST_SCAN))
        else $error("token present outside a scan");

    // Occupancy never exceeds the depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    // A served result removes exactly one entry
    a_serve_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == cstq_pkg::ST_SERVED)
        |-> (OCC_W'(occ_reg + 1'b1) == $past(occ_reg)))
        else $error("serve did not remove one entry");

endmodule

`default_nettype wire

// ===== sim/ticket_queue_checker.sv =====
// Checker for the class-selective ticket queue: tracks its own copy of the
// ticket line, predicts each result and compares it with what the block shows.
// Depends on cstq_pkg.
`timescale 1ns / 1ps

module ticket_queue_checker #(
    parameter int DEPTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire                          op,
    input  wire  [cstq_pkg::CLS_W-1:0]   ticket_class,
    input  wire  [1:0]                   window,
    input  wire                          cfg_we,
    input  wire  [cstq_pkg::MAP_W-1:0]   cfg_wdata,
    input  wire                          done,
    input  wire  [cstq_pkg::STAT_W-1:0]  status,
    input  wire  [cstq_pkg::NUM_W-1:0]   served_number,
    input  wire  [cstq_pkg::CLS_W-1:0]   served_class,
    input  wire  [cstq_pkg::CNT_W-1:0]   queue_count,
    output int                           mismatches,
    output int                           owed,
    output int                           results_checked,
    output int                           served_hits,
    output int                           full_hits,
    output int                           nomatch_hits
);

    typedef struct packed {
        logic [cstq_pkg::NUM_W-1:0] num;
        logic [cstq_pkg::CLS_W-1:0] cls;
    } ticket_t;

    typedef struct packed {
        logic [cstq_pkg::STAT_W-1:0] status;
        logic [cstq_pkg::NUM_W-1:0]  num;
        logic [cstq_pkg::CLS_W-1:0]  cls;
        logic [cstq_pkg::CNT_W-1:0]  count;
    } reply_t;

    ticket_t                    waiting_line[$];
    reply_t                     owed_replies[$];
    logic [cstq_pkg::NUM_W-1:0] next_num   = cstq_pkg::NUM_RESET;
    logic [cstq_pkg::MAP_W-1:0] window_map = cstq_pkg::MAP_RESET;

    int mismatch_count = 0;
    int owed_count     = 0;
    int checked_count  = 0;
    int served_count   = 0;
    int full_count     = 0;
    int nomatch_count  = 0;

    assign mismatches      = mismatch_count;
    assign owed            = owed_count;
    assign results_checked = checked_count;
    assign served_hits     = served_count;
    assign full_hits       = full_count;
    assign nomatch_hits    = nomatch_count;

    // Apply one item to the line and return the reply it should produce
    function automatic reply_t apply_ticket_op(input logic op_i,
                                               input logic [cstq_pkg::CLS_W-1:0] cls_i,
                                               input logic [1:0] win_i);
        reply_t                     r;
        ticket_t                    t;
        logic [cstq_pkg::CLS_W-1:0] want;
        int                         hit;
        r   = '0;
        hit = -1;
        if (op_i == cstq_pkg::OP_ISSUE)
        begin
            // fullness wins over a bad class
            if (waiting_line.size() >= DEPTH)
            begin
                r.status = cstq_pkg::ST_FULL;
            end
            else if (cls_i == cstq_pkg::CLS_INVALID)
            begin
                r.status = cstq_pkg::ST_BADCLASS;
            end
            else
            begin
                t.num = next_num;
                t.cls = cls_i;
                waiting_line.push_back(t);
                r.status = cstq_pkg::ST_ISSUED;
                r.num    = next_num;
                r.cls    = cls_i;
                next_num = next_num + 1'b1;
            end
        end
        else if (waiting_line.size() == 0)
        begin
            r.status = cstq_pkg::ST_EMPTY;
        end
        else
        begin
            // take the oldest ticket of the class mapped to this window
            want = window_map[2*win_i +: 2];
            foreach (waiting_line[i])
                if (hit < 0 && waiting_line[i].cls == want)
                    hit = i;
            if (hit < 0)
            begin
                r.status = cstq_pkg::ST_NOMATCH;
            end
            else
            begin
                r.status = cstq_pkg::ST_SERVED;
                r.num    = waiting_line[hit].num;
                r.cls    = waiting_line[hit].cls;
                waiting_line.delete(hit);
            end
        end
        r.count = cstq_pkg::CNT_W'(waiting_line.size());
        return r;
    endfunction

    // Compare results, follow map writes, then predict newly taken items
    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want_r;
        if (!rst_n)
        begin
            waiting_line.delete();
            owed_replies.delete();
            next_num   = cstq_pkg::NUM_RESET;
            window_map = cstq_pkg::MAP_RESET;
            owed_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("result with status %0d arrived with nothing outstanding",
                           status);
                    mismatch_count++;
                end
                else
                begin
                    want_r = owed_replies.pop_front();
                    checked_count++;
                    if (want_r.status == cstq_pkg::ST_SERVED)  served_count++;
                    if (want_r.status == cstq_pkg::ST_FULL)    full_count++;
                    if (want_r.status == cstq_pkg::ST_NOMATCH) nomatch_count++;
                    if (status !== want_r.status)
                    begin
                        $error("status: expected %0d, got %0d", want_r.status, status);
                        mismatch_count++;
                    end
                    if (served_number !== want_r.num)
                    begin
                        $error("served_number: expected %0d, got %0d",
                               want_r.num, served_number);
                        mismatch_count++;
                    end
                    if (served_class !== want_r.cls)
                    begin
                        $error("served_class: expected %0d, got %0d",
                               want_r.cls, served_class);
                        mismatch_count++;
                    end
                    if (queue_count !== want_r.count)
                    begin
                        $error("queue_count: expected %0d, got %0d",
                               want_r.count, queue_count);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we)
                window_map = cfg_wdata;
            if (start && !busy)
                owed_replies.push_back(apply_ticket_op(op, ticket_class, window));
            owed_count = owed_replies.size();
        end
    end

endmodule

// ===== sim/tb_class_selective_ticket_queue.sv =====
// Testbench top for the class-selective ticket queue: clock, reset, stimulus
// and verdict. Depends on cstq_pkg, class_selective_ticket_queue and
// ticket_queue_checker.
`timescale 1ns / 1ps

module tb_class_selective_ticket_queue;

    localparam int DEPTH        = 32;
    localparam int STALL_LIMIT  = 8 * (DEPTH + 8);
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 65;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         op;
    logic [cstq_pkg::CLS_W-1:0]   ticket_class;
    logic [1:0]                   window;
    logic                         cfg_we;
    logic [cstq_pkg::MAP_W-1:0]   cfg_wdata;
    logic                         busy;
    logic                         done;
    logic [cstq_pkg::STAT_W-1:0]  status;
    logic [cstq_pkg::NUM_W-1:0]   served_number;
    logic [cstq_pkg::CLS_W-1:0]   served_class;
    logic [cstq_pkg::CNT_W-1:0]   queue_count;

    int mismatches;
    int owed;
    int results_checked;
    int served_hits;
    int full_hits;
    int nomatch_hits;
    int issue_items = 0;
    int serve_items = 0;
    int map_loads   = 0;
    int stall_cycles;

    class_selective_ticket_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .ticket_class  (ticket_class),
        .window        (window),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .served_number (served_number),
        .served_class  (served_class),
        .queue_count   (queue_count)
    );

    ticket_queue_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .ticket_class    (ticket_class),
        .window          (window),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .status          (status),
        .served_number   (served_number),
        .served_class    (served_class),
        .queue_count     (queue_count),
        .mismatches      (mismatches),
        .owed            (owed),
        .results_checked (results_checked),
        .served_hits     (served_hits),
        .full_hits       (full_hits),
        .nomatch_hits    (nomatch_hits)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Present one item and hold it until the block takes it
    task automatic send_ticket_op(input logic op_i,
                                  input logic [cstq_pkg::CLS_W-1:0] cls_i,
                                  input logic [1:0] win_i);
        @(negedge clk);
        start        <= 1'b1;
        op           <= op_i;
        ticket_class <= cls_i;
        window       <= win_i;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op_i == cstq_pkg::OP_ISSUE)
            issue_items++;
        else
            serve_items++;
    endtask

    // Drop start for a number of cycles
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Drain outstanding work, then write the window map
    task automatic load_window_map(input logic [cstq_pkg::MAP_W-1:0] map_v);
        idle_sender(1);
        while (owed != 0)
            @(posedge clk);
        repeat (DEPTH + 2)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= map_v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        map_loads++;
    endtask

    // Stall watchdog: end the run if nothing moves for too long
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_class_selective_ticket_queue: done, errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [cstq_pkg::MAP_W-1:0] phase_maps [PHASES];
        logic                       rnd_op;
        logic [cstq_pkg::CLS_W-1:0] rnd_cls;
        logic [1:0]                 rnd_win;
        int                         serve_pct;
        int                         burst;
        int                         sent;
        bit                         gappy;

        rst_n        = 1'b0;
        start        = 1'b0;
        op           = cstq_pkg::OP_ISSUE;
        ticket_class = cstq_pkg::CLS_COMMON;
        window       = 2'd0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        phase_maps   = '{cstq_pkg::MAP_RESET, 8'hE4, 8'h00,
                         cstq_pkg::MAP_W'($urandom), 8'hFF, 8'h1B,
                         cstq_pkg::MAP_W'($urandom), 8'h55, 8'hAA,
                         cstq_pkg::MAP_W'($urandom)};

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty serve, bad class, a ticket of each class and a second common
        // one, then serve every window under the reset map including a miss
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_INVALID, 2'd0);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_INVALID, 2'd3);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_COMMON, 2'd0);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_PRIORITY, 2'd1);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_FAST, 2'd2);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_COMMON, 2'd3);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_COMMON, 2'd3);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_FAST, 2'd3);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_PRIORITY, 2'd1);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_COMMON, 2'd0);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_INVALID, 2'd2);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_COMMON, 2'd0);

        // Map of all threes: every window misses
        load_window_map(8'hFF);
        send_ticket_op(cstq_pkg::OP_ISSUE, cstq_pkg::CLS_COMMON, 2'd1);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_COMMON, 2'd0);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_PRIORITY, 2'd1);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_FAST, 2'd2);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_INVALID, 2'd3);

        // Map of all zeros: every window serves common
        load_window_map(8'h00);
        send_ticket_op(cstq_pkg::OP_SERVE, cstq_pkg::CLS_FAST, 2'd2);

        // Random phases: fill, drain and mixed traffic under changing maps
        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_window_map(phase_maps[phase]);
            serve_pct = (phase % 3 == 0) ? 20 : (phase % 3 == 1) ? 80 : 50;
            gappy     = ($urandom_range(0, 3) != 0);
            sent      = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    rnd_op  = ($urandom_range(0, 99) < serve_pct) ? cstq_pkg::OP_SERVE
                                                                  : cstq_pkg::OP_ISSUE;
                    rnd_cls = ($urandom_range(0, 9) == 0)
                              ? cstq_pkg::CLS_INVALID
                              : cstq_pkg::CLS_W'($urandom_range(0, 2));
                    rnd_win = 2'($urandom_range(0, 3));
                    send_ticket_op(rnd_op, rnd_cls, rnd_win);
                    sent++;
                end
                if (gappy)
                    idle_sender($urandom_range(1, 6));
            end
        end

        // Let the last results come back, then give the verdict
        idle_sender(1);
        while (owed != 0)
            @(posedge clk);
        repeat (DEPTH + 4)
            @(posedge clk);

        $display("covered %0d issue and %0d serve items under %0d window map writes",
                 issue_items, serve_items, map_loads);
        $display("checked %0d results: %0d served, %0d refused as full, %0d unmatched",
                 results_checked, served_hits, full_hits, nomatch_hits);
        if (mismatches == 0 && owed == 0)
            $display("tb_class_selective_ticket_queue: done, clean");
        else
            $display("tb_class_selective_ticket_queue: done, errors");
        $finish;
    end

endmodule
